[hdl/qvpd_pkg.sv]
// Shared types, opcode classes and channel helpers for the pixel decoder.
`timescale 1ns / 1ps

package qvpd_pkg;

    localparam int INDEX_ENTRIES = 64;

    // configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DATA_LENGTH  = 2'd2;

    // opcode classes
    localparam logic [2:0] K_INDEX    = 3'd0;
    localparam logic [2:0] K_RUN      = 3'd1;
    localparam logic [2:0] K_RUN_LONG = 3'd2;
    localparam logic [2:0] K_DIFF     = 3'd3;
    localparam logic [2:0] K_LUMA     = 3'd4;
    localparam logic [2:0] K_DELTA5   = 3'd5;
    localparam logic [2:0] K_LITERAL  = 3'd6;

    typedef struct packed {
        logic [7:0] alpha;
        logic [7:0] blue;
        logic [7:0] green;
        logic [7:0] red;
    } color_t;

    localparam color_t COLOR_RESET = '{alpha: 8'hFF, blue: 8'h00, green: 8'h00, red: 8'h00};

    // one decoded request handed from the byte stage to the colour stage
    typedef struct packed {
        logic        valid;
        logic        finish;
        logic        emit;
        logic        last;
        logic [7:0]  op;
        logic [31:0] tail;
        logic [31:0] rep;
    } exec_req_t;

    function automatic logic [2:0] op_kind(input logic [7:0] b);
        logic [2:0] k;
        if (b[7:6] == 2'b00)         k = K_INDEX;
        else if (b[7:5] == 3'b010)   k = K_RUN;
        else if (b[7:5] == 3'b011)   k = K_RUN_LONG;
        else if (b[7:6] == 2'b10)    k = K_DIFF;
        else if (b[7:5] == 3'b110)   k = K_LUMA;
        else if (b[7:4] == 4'b1110)  k = K_DELTA5;
        else                         k = K_LITERAL;
        return k;
    endfunction

    function automatic logic [2:0] flag_count(input logic [3:0] f);
        return 3'({2'b0, f[3]} + {2'b0, f[2]} + {2'b0, f[1]} + {2'b0, f[0]});
    endfunction

    function automatic logic [2:0] extra_bytes(input logic [7:0] b);
        logic [2:0] n;
        case (op_kind(b))
            K_RUN_LONG, K_LUMA: n = 3'd1;
            K_DELTA5:           n = 3'd2;
            K_LITERAL:          n = flag_count(b[3:0]);
            default:            n = 3'd0;
        endcase
        return n;
    endfunction

endpackage

[hdl/qvpd_ctrl.sv]
// Byte stage: opcode gathering, byte and pixel accounting, repeat clipping.
`timescale 1ns / 1ps

module qvpd_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                take,         // request accepted this cycle
    input  logic                load,         // colour stage register may load
    input  logic                recalc,       // rebuild remaining count from total
    input  logic                in_finish,
    input  logic [7:0]          in_byte,
    input  logic [31:0]         total,
    input  logic [31:0]         data_length,
    output logic [7:0]          rd_op,
    output qvpd_pkg::exec_req_t req
);

    logic [31:0]         consumed_reg, consumed_next;
    logic [2:0]          needed_reg, needed_next;
    logic [23:0]         gathered_reg, gathered_next;
    logic [7:0]          pending_reg, pending_next;
    logic [31:0]         emitted_reg, emitted_next;
    logic [31:0]         remaining_reg, remaining_next;
    qvpd_pkg::exec_req_t req_reg, req_next;

    logic        complete;
    logic [7:0]  op_byte;
    logic [31:0] tail;
    logic [13:0] rep_raw;
    logic [31:0] clip;
    logic [2:0]  kind;
    logic [2:0]  n_extra;

    // with nothing pending the byte itself is the opcode and carries no tail
    assign op_byte = (needed_reg == 3'd0) ? in_byte : pending_reg;
    assign tail    = (needed_reg == 3'd0) ? 32'd0 : {gathered_reg, in_byte};
    assign kind    = qvpd_pkg::op_kind(op_byte);
    assign n_extra = qvpd_pkg::extra_bytes(in_byte);

    always_comb begin
        case (kind)
            qvpd_pkg::K_RUN:      rep_raw = 14'({9'b0, op_byte[4:0]} + 14'd1);
            qvpd_pkg::K_RUN_LONG: rep_raw = 14'({1'b0, op_byte[4:0], tail[7:0]} + 14'd33);
            default:              rep_raw = 14'd1;
        endcase
    end

    always_comb begin
        consumed_next  = consumed_reg;
        needed_next    = needed_reg;
        gathered_next  = gathered_reg;
        pending_next   = pending_reg;
        emitted_next   = emitted_reg;
        remaining_next = remaining_reg;
        req_next       = '0;
        complete       = 1'b0;
        clip           = '0;

        if (recalc) begin
            remaining_next = (total > emitted_reg) ? total - emitted_reg : 32'd0;
        end else if (take) begin
            if (in_finish) begin
                req_next.valid  = 1'b1;
                req_next.finish = 1'b1;
                req_next.emit   = (remaining_reg != 32'd0);
                req_next.last   = 1'b1;
                req_next.rep    = remaining_reg;
                consumed_next   = '0;
                needed_next     = '0;
                gathered_next   = '0;
                pending_next    = '0;
                emitted_next    = '0;
                remaining_next  = total;
            end else if (needed_reg == 3'd0) begin
                // new opcode only while data and pixels are left
                if (remaining_reg != 32'd0 && consumed_reg < data_length) begin
                    consumed_next = consumed_reg + 32'd1;
                    pending_next  = in_byte;
                    needed_next   = n_extra;
                    gathered_next = '0;
                    if (n_extra == 3'd0) begin
                        complete = 1'b1;
                    end
                end
            end else begin
                if (consumed_reg != '1) consumed_next = consumed_reg + 32'd1;
                needed_next = needed_reg - 3'd1;
                if (needed_reg != 3'd1) begin
                    gathered_next = {gathered_reg[15:0], in_byte};
                end else begin
                    complete      = 1'b1;
                    gathered_next = '0;
                end
            end

            if (complete) begin
                req_next.valid = 1'b1;
                req_next.emit  = (remaining_reg != 32'd0);
                req_next.op    = op_byte;
                req_next.tail  = tail;
                if ({18'b0, rep_raw} >= remaining_reg) begin
                    clip          = remaining_reg;
                    req_next.last = 1'b1;
                end else begin
                    clip = {18'b0, rep_raw};
                end
                req_next.rep   = clip;
                remaining_next = remaining_reg - clip;
                emitted_next   = emitted_reg + clip;
            end
        end
    end

    assign rd_op = op_byte;
    assign req   = req_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            consumed_reg  <= '0;
            needed_reg    <= '0;
            gathered_reg  <= '0;
            pending_reg   <= '0;
            emitted_reg   <= '0;
            remaining_reg <= '0;
            req_reg       <= '0;
        end else begin
            consumed_reg  <= consumed_next;
            needed_reg    <= needed_next;
            gathered_reg  <= gathered_next;
            pending_reg   <= pending_next;
            emitted_reg   <= emitted_next;
            remaining_reg <= remaining_next;
            if (load) req_reg <= req_next;
        end
    end

endmodule

[hdl/qvpd_color.sv]
// Colour stage: current colour, hashed colour table memory and pixel result.
`timescale 1ns / 1ps

module qvpd_color #(
    parameter int INDEX_ENTRIES = qvpd_pkg::INDEX_ENTRIES
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                load,       // a new request enters this stage
    input  logic                en,         // the request here is executed
    input  logic [7:0]          rd_op,
    input  qvpd_pkg::exec_req_t req,
    output logic                res_valid,
    output qvpd_pkg::color_t    res_color,
    output logic [31:0]         res_rep,
    output logic                res_last
);

    localparam int IDX_W = $clog2(INDEX_ENTRIES);

    qvpd_pkg::color_t idx_mem [INDEX_ENTRIES];
    qvpd_pkg::color_t rd_data_reg;
    logic [INDEX_ENTRIES-1:0] valid_reg;
    qvpd_pkg::color_t color_reg;
    logic             fwd_valid_reg;
    logic [IDX_W-1:0] fwd_addr_reg;
    qvpd_pkg::color_t fwd_data_reg;

    qvpd_pkg::color_t entry, cur, color_new;
    logic [IDX_W-1:0] rd_addr, hash;
    logic [7:0]       hbyte;
    logic             wr;
    logic [2:0]       n;

    function automatic logic [7:0] pick(input logic [31:0] t, input logic [1:0] k);
        return t[{k, 3'b000} +: 8];
    endfunction

    assign rd_addr = req.op[IDX_W-1:0];

    // last write is forwarded when it lands on the entry read alongside it
    always_comb begin
        if (fwd_valid_reg && fwd_addr_reg == rd_addr) entry = fwd_data_reg;
        else if (valid_reg[rd_addr])                  entry = rd_data_reg;
        else                                          entry = '0;
    end

    always_comb begin
        cur       = color_reg;
        color_new = color_reg;
        n         = qvpd_pkg::flag_count(req.op[3:0]);
        case (qvpd_pkg::op_kind(req.op))
            qvpd_pkg::K_INDEX: color_new = entry;
            qvpd_pkg::K_DIFF: begin
                color_new.red   = cur.red   + {{6{req.op[5]}}, req.op[5:4]};
                color_new.green = cur.green + {{6{req.op[3]}}, req.op[3:2]};
                color_new.blue  = cur.blue  + {{6{req.op[1]}}, req.op[1:0]};
            end
            qvpd_pkg::K_LUMA: begin
                color_new.red   = cur.red   + {{3{req.op[4]}}, req.op[4:0]};
                color_new.green = cur.green + {{4{req.tail[7]}}, req.tail[7:4]};
                color_new.blue  = cur.blue  + {{4{req.tail[3]}}, req.tail[3:0]};
            end
            qvpd_pkg::K_DELTA5: begin
                color_new.red   = cur.red   + {{3{req.op[3]}}, req.op[3:0], req.tail[15]};
                color_new.green = cur.green + {{3{req.tail[14]}}, req.tail[14:10]};
                color_new.blue  = cur.blue  + {{3{req.tail[9]}}, req.tail[9:5]};
                color_new.alpha = cur.alpha + {{3{req.tail[4]}}, req.tail[4:0]};
            end
            qvpd_pkg::K_LITERAL: begin
                // literal bytes arrive r, g, b, a; the first sits highest in the tail
                if (req.op[3]) begin n = n - 3'd1; color_new.red   = pick(req.tail, n[1:0]); end
                if (req.op[2]) begin n = n - 3'd1; color_new.green = pick(req.tail, n[1:0]); end
                if (req.op[1]) begin n = n - 3'd1; color_new.blue  = pick(req.tail, n[1:0]); end
                if (req.op[0]) begin n = n - 3'd1; color_new.alpha = pick(req.tail, n[1:0]); end
            end
            default: color_new = cur;
        endcase
    end

    assign hbyte = color_new.red ^ color_new.green ^ color_new.blue ^ color_new.alpha;
    assign hash  = hbyte[IDX_W-1:0];
    assign wr    = en && req.valid && !req.finish;

    assign res_valid = req.valid && req.emit;
    assign res_color = req.finish ? color_reg : color_new;
    assign res_rep   = req.rep;
    assign res_last  = req.last;

    always_ff @(posedge aclk) begin
        if (load) rd_data_reg <= idx_mem[rd_op[IDX_W-1:0]];
        if (wr)   idx_mem[hash] <= color_new;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            fwd_addr_reg <= hash;
            fwd_data_reg <= color_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg     <= '0;
            color_reg     <= qvpd_pkg::COLOR_RESET;
            fwd_valid_reg <= 1'b0;
        end else if (en) begin
            fwd_valid_reg <= wr;
            if (req.valid) begin
                if (req.finish) begin
                    color_reg <= qvpd_pkg::COLOR_RESET;
                    valid_reg <= '0;
                end else begin
                    color_reg       <= color_new;
                    valid_reg[hash] <= 1'b1;
                end
            end
        end
    end

endmodule

[hdl/qoi_variant_pixel_decoder.sv]
// Top level of the seven-opcode QOI-style pixel decoder with BGRA run output.
//
// Compressed bytes enter on the s_ stream, one per request; s_tuser set marks a
// finish request that fills the rest of the image with the current colour and
// resets the colour, the table and all counters. Each completed opcode gives one
// BGRA pixel with a repeat count on the m_ stream; m_tlast flags the pixels that
// complete the image. The user must write image size and data length on the cfg_
// port only while the block is idle; the block does not enforce it. cfg_ready is
// always high. Throughput: one byte per cycle unless the output stalls or a
// count rebuild holds the input. Accepting the byte that completes an opcode
// loads the colour stage register, then the colour stage runs it against the
// table and loads the output register that drives m_tvalid. The input stays
// ready while the output register holds an untaken result, as long as the
// colour stage register is free; a stalled receiver then holds both.
// After reset, and for one cycle after every configuration write, s_tready is
// low while the remaining pixel count is rebuilt. Reset clears the table valid
// bits at once, so the table reads as all zero with no clearing pass.
`timescale 1ns / 1ps

module qoi_variant_pixel_decoder #(
    parameter int INDEX_ENTRIES = qvpd_pkg::INDEX_ENTRIES
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] data_byte
    input  logic        s_tuser,    // [0] opcode (1 = finish)
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata,    // blue, green, red, alpha, repeat_count[31:0]
    output logic        m_tlast,    // image_done
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [qvpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0] cfg_data
);

    logic [15:0] width_reg, width_next;
    logic [15:0] height_reg, height_next;
    logic [31:0] dlen_reg, dlen_next;
    logic [31:0] total_reg, total_next;
    logic        recalc_reg;
    logic        m_tvalid_reg;
    logic [63:0] m_tdata_reg;
    logic        m_tlast_reg;

    logic                en, load, take, cfg_take;
    logic [7:0]          rd_op;
    qvpd_pkg::exec_req_t req;
    logic                res_valid, res_last;
    qvpd_pkg::color_t    res_color;
    logic [31:0]         res_rep;

    assign en       = !m_tvalid_reg || m_tready;
    assign load     = en || !req.valid;
    assign s_tready = load && !recalc_reg;
    assign take     = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_take  = cfg_valid;

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        dlen_next   = dlen_reg;
        if (cfg_take) begin
            unique case (cfg_index)
                qvpd_pkg::REG_IMAGE_WIDTH:  width_next  = cfg_data[15:0];
                qvpd_pkg::REG_IMAGE_HEIGHT: height_next = cfg_data[15:0];
                qvpd_pkg::REG_DATA_LENGTH:  dlen_next   = cfg_data;
                default: ;
            endcase
        end
        total_next = 32'(width_next) * 32'(height_next);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg    <= 16'd1;
            height_reg   <= 16'd1;
            dlen_reg     <= '0;
            total_reg    <= 32'd1;
            recalc_reg   <= 1'b1;
            m_tvalid_reg <= 1'b0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            dlen_reg   <= dlen_next;
            total_reg  <= total_next;
            recalc_reg <= cfg_take;
            if (en) m_tvalid_reg <= res_valid && en && req.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (en && res_valid) begin
            m_tdata_reg <= {res_rep, res_color.alpha, res_color.red,
                            res_color.green, res_color.blue};
            m_tlast_reg <= res_last;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;

    qvpd_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .take        (take),
        .load        (load),
        .recalc      (recalc_reg),
        .in_finish   (s_tuser),
        .in_byte     (s_tdata),
        .total       (total_reg),
        .data_length (dlen_reg),
        .rd_op       (rd_op),
        .req         (req)
    );

    qvpd_color #(
        .INDEX_ENTRIES (INDEX_ENTRIES)
    ) u_color (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (load),
        .en        (en),
        .rd_op     (rd_op),
        .req       (req),
        .res_valid (res_valid),
        .res_color (res_color),
        .res_rep   (res_rep),
        .res_last  (res_last)
    );

endmodule

[hdl/qvpd_checker.sv]
// Port-level checks on the pixel decoder, bound to its top level.
`timescale 1ns / 1ps

module qvpd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [63:0] m_tdata,
    input logic        m_tlast,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [qvpd_pkg::CFG_IDX_W-1:0] cfg_index,
    input logic [31:0] cfg_data
);

    // stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("stalled result changed");

    // every result covers at least one pixel
    a_rep: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[63:32] != 32'd0)
        else $error("zero repeat count");

    // input held off while remaining count is rebuilt after a register write
    a_cfg: assert property (@(posedge aclk) disable iff (!aresetn)
        cfg_valid && cfg_ready |=> !s_tready)
        else $error("request taken during count rebuild");

    // reset leaves no result and no request taken in the following cycle
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && !s_tready)
        else $error("activity straight after reset");

endmodule

bind qoi_variant_pixel_decoder qvpd_checker u_qvpd_checker (.*);
